// ===== design/cvrp_pkg.sv =====
// Package for the tour split cost core: payload structs, request and
// command codes, sequencer phases and default sizes. No dependencies.
`default_nettype none

package cvrp_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_POINTS_DEF   = 256;
    localparam int DIST_WIDTH_DEF   = 16;
    localparam int DEMAND_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int PT_W   = 8;
    localparam int VAL_W  = 16;
    localparam int CAP_W  = 16;
    localparam int COST_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = '1;

    // Queue depths
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_DIST_WR = 2'd0,
        REQ_DEM_WR  = 2'd1,
        REQ_VISIT   = 2'd2
    } req_t;

    // Command codes held in the command queue
    typedef enum logic [1:0] {
        OP_DIST_WR = 2'd0,
        OP_DEM_WR  = 2'd1,
        OP_VISIT   = 2'd2
    } op_t;

    localparam int OP_W = $bits(op_t);

    // Back-end sequencer phases
    typedef enum logic [0:0] {
        PH_SLOT = 1'b0,
        PH_PREV = 1'b1
    } phase_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [PT_W-1:0]  dist_row;
        logic [PT_W-1:0]  dist_col;
        logic [VAL_W-1:0] dist_value;
        logic [PT_W-1:0]  demand_point;
        logic [VAL_W-1:0] demand_value;
        logic [PT_W-1:0]  tour_point;
        logic             tour_last;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0] running_cost;
        logic              new_subroute;
        logic              over_capacity;
        logic              tour_done;
    } out_item_t;

endpackage

`default_nettype wire

// ===== design/cvrp_tour_split_cost_core.sv =====
// Tour split cost core: top level. Holds the capacity register and joins
// the front end, command queue and back end. Uses cvrp_pkg.
//
// The core evaluates the cost of one vehicle tour. Load the distance table
// (req_type 0, row/column/value) and the demand table (req_type 1) first;
// neither table is cleared by reset, so every entry a tour touches must be
// written beforehand. Then send the tour's points in order (req_type 2),
// leaving out the depot (point 0), and mark the final one with tour_last.
// Points are packed greedily into subroutes of at most vehicle_capacity
// summed demand: when the next demand would overflow, the return to the
// depot is charged and the point starts a fresh subroute from the depot.
// A point whose own demand exceeds the capacity is skipped and flagged with
// over_capacity. Every visit gives one result with the running cost
// (saturating at all ones); the result of the last point carries the
// closing return and tour_done, and the running state is then cleared for
// the next tour. Table writes give no result; request type 3 is dropped.
// Point numbers at or beyond MAX_POINTS wrap modulo MAX_POINTS.
// A table write holds the back end for the slot phase only, a visit for
// the slot and previous-point phases, both bound by the two ports of the
// distance memory (slot: demand and the two depot legs, previous point:
// the two legs from the previous point). A visit's result passes the table
// read, decision and cost registers; results wait in a four-entry result
// queue while the input side keeps accepting into a four-entry command
// queue. Write vehicle_capacity only while no tour point is in flight.
`default_nettype none

module cvrp_tour_split_cost_core import cvrp_pkg::*; #(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int DIST_WIDTH   = DIST_WIDTH_DEF,
    parameter int DEMAND_WIDTH = DEMAND_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // capacity register write
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data,
    // request channel
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    // result channel
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int AW    = $clog2(MAX_POINTS * MAX_POINTS);
    localparam int QW    = OP_W + 1 + VAL_W + IDX_W + AW;

    logic [CAP_W-1:0] cap_reg;

    // front end to command queue
    logic          f_push, f_ready;
    logic [QW-1:0] f_data;

    // command queue to back end
    logic          b_valid, b_pop;
    logic [QW-1:0] b_data;

    // Capacity register: take a write whenever enable is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Classify requests and form table addresses
    cvrp_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .q_push  (f_push),
        .q_data  (f_data),
        .q_ready (f_ready)
    );

    // Decouple the front from the two-phase back end
    cvrp_queue #(
        .WIDTH (QW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_push),
        .push_data  (f_data),
        .push_ready (f_ready),
        .pop        (b_pop),
        .pop_data   (b_data),
        .pop_valid  (b_valid)
    );

    // Tables, split decision, cost and result queue
    cvrp_back #(
        .MAX_POINTS   (MAX_POINTS),
        .DIST_WIDTH   (DIST_WIDTH),
        .DEMAND_WIDTH (DEMAND_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .vehicle_capacity (cap_reg),
        .q_valid          (b_valid),
        .q_data           (b_data),
        .q_pop            (b_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

endmodule

`default_nettype wire

// ===== design/cvrp_queue.sv =====
// Small register queue with valid/ready style push and pop sides.
// Used for the command queue and the result queue; no package needed.
`default_nettype none

module cvrp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  pop_valid
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/cvrp_front.sv =====
// Front end: classifies incoming requests, folds point numbers into range
// and forms table addresses for the command queue. Uses cvrp_pkg.
`default_nettype none

module cvrp_front import cvrp_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    localparam int IDX_W = $clog2(MAX_POINTS),
    localparam int AW    = $clog2(MAX_POINTS * MAX_POINTS),
    localparam int QW    = OP_W + 1 + VAL_W + IDX_W + AW
) (
    input  wire logic     s_valid,
    input  wire in_item_t s_data,
    output logic          s_ready,
    output logic          q_push,
    output logic [QW-1:0] q_data,
    input  wire logic     q_ready
);

    localparam int TAB_N = 2 ** PT_W;

    typedef struct packed {
        op_t              op;
        logic             last;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] pt;
        logic [AW-1:0]    addr;
    } cmd_t;

    // Fold every 8-bit point number into 0 .. MAX_POINTS-1
    function automatic logic [TAB_N*IDX_W-1:0] build_fold_tab();
        logic [TAB_N*IDX_W-1:0] t;
        int                     r;
        t = '0;
        r = 0;
        for (int i = 0; i < TAB_N; i++) begin
            t[i*IDX_W +: IDX_W] = IDX_W'(r);
            r = (r == MAX_POINTS - 1) ? 0 : r + 1;
        end
        return t;
    endfunction

    localparam logic [TAB_N*IDX_W-1:0] FOLD_TAB = build_fold_tab();

    function automatic logic [IDX_W-1:0] fold(input logic [PT_W-1:0] v);
        return FOLD_TAB[int'(v)*IDX_W +: IDX_W];
    endfunction

    cmd_t             cmd;
    logic             keep;
    logic [IDX_W-1:0] row_idx, col_idx, dem_idx, tour_idx;

    assign row_idx  = fold(s_data.dist_row);
    assign col_idx  = fold(s_data.dist_col);
    assign dem_idx  = fold(s_data.demand_point);
    assign tour_idx = fold(s_data.tour_point);

    always_comb begin
        cmd  = '0;
        keep = 1'b0;
        case (s_data.req_type)
            REQ_DIST_WR: begin
                keep      = 1'b1;
                cmd.op    = OP_DIST_WR;
                cmd.value = s_data.dist_value;
                cmd.addr  = AW'(row_idx) * AW'(MAX_POINTS) + AW'(col_idx);
            end
            REQ_DEM_WR: begin
                keep      = 1'b1;
                cmd.op    = OP_DEM_WR;
                cmd.value = s_data.demand_value;
                cmd.pt    = dem_idx;
            end
            REQ_VISIT: begin
                keep     = 1'b1;
                cmd.op   = OP_VISIT;
                cmd.last = s_data.tour_last;
                cmd.pt   = tour_idx;
                // row base of the point: p * MAX_POINTS
                cmd.addr = AW'(tour_idx) * AW'(MAX_POINTS);
            end
            default: begin
                // unknown request: drop
                keep = 1'b0;
            end
        endcase
    end

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready && keep;
    assign q_data  = cmd;

endmodule

`default_nettype wire

// ===== design/cvrp_back.sv =====
// Back end: owns the distance and demand tables, runs the two-phase visit
// sequence, the split decision, the saturating cost and the result queue.
// Uses cvrp_pkg and cvrp_queue.
`default_nettype none

module cvrp_back import cvrp_pkg::*; #(
    parameter int MAX_POINTS   = MAX_POINTS_DEF,
    parameter int DIST_WIDTH   = DIST_WIDTH_DEF,
    parameter int DEMAND_WIDTH = DEMAND_WIDTH_DEF,
    localparam int IDX_W = $clog2(MAX_POINTS),
    localparam int AW    = $clog2(MAX_POINTS * MAX_POINTS),
    localparam int QW    = OP_W + 1 + VAL_W + IDX_W + AW
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [CAP_W-1:0] vehicle_capacity,
    input  wire logic             q_valid,
    input  wire logic [QW-1:0]    q_data,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data
);

    localparam int CMP_W   = ((DEMAND_WIDTH > CAP_W) ? DEMAND_WIDTH : CAP_W) + 1;
    localparam int DELTA_W = DIST_WIDTH + 2;
    localparam int SUM_W   = ((DELTA_W > COST_W) ? DELTA_W : COST_W) + 1;
    localparam int CRED_W  = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        op_t              op;
        logic             last;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] pt;
        logic [AW-1:0]    addr;
    } cmd_t;

    cmd_t cmd;
    assign cmd = cmd_t'(q_data);

    // Sequencer
    phase_t              state_reg, state_next;
    logic                visit_pop, dist_we, dem_we, rd_en;
    logic [AW-1:0]       a_addr, b_addr;
    logic [CRED_W-1:0]   credit_reg, credit_next;

    // Tables
    logic [DIST_WIDTH-1:0]   dist_mem [MAX_POINTS * MAX_POINTS];
    logic [DEMAND_WIDTH-1:0] dem_mem  [MAX_POINTS];
    logic [DIST_WIDTH-1:0]   rd_a_reg, rd_b_reg;
    logic [DEMAND_WIDTH-1:0] need_reg;

    // Visit in flight
    logic [IDX_W-1:0]      v_pt_reg;
    logic [AW-1:0]         v_base_reg;
    logic                  v_last_reg;
    logic [DIST_WIDTH-1:0] d0p_reg, dp0_reg;

    // Running state
    logic [CAP_W-1:0]  load_reg, load_next;
    logic [AW-1:0]     prev_base_reg, prev_base_next;
    logic [COST_W-1:0] cost_reg, cost_next;

    // Decision stage
    logic                  c_valid_reg;
    logic [CMP_W-1:0]      need_x, cap_x, load_x, sum_x;
    logic                  over, ret, fresh;
    logic [CAP_W-1:0]      load_new;
    logic [DIST_WIDTH-1:0] leg;
    logic [DELTA_W-1:0]    delta;

    // Cost stage
    logic               s3_valid_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic               s3_fresh_reg, s3_over_reg, s3_last_reg;
    logic [SUM_W-1:0]   sum_w;
    logic [COST_W-1:0]  cost_sat;
    out_item_t          res;
    logic               o_ready;

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            PH_SLOT: begin
                if (visit_pop) begin
                    state_next = PH_PREV;
                end
            end
            PH_PREV: state_next = PH_SLOT;
            default: state_next = PH_SLOT;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        q_pop     = 1'b0;
        visit_pop = 1'b0;
        dist_we   = 1'b0;
        dem_we    = 1'b0;
        rd_en     = 1'b0;
        a_addr    = '0;
        b_addr    = '0;
        case (state_reg)
            PH_SLOT: begin
                // a visit needs a free place in the result queue
                q_pop     = q_valid && ((cmd.op != OP_VISIT) || (credit_reg != '0));
                visit_pop = q_pop && (cmd.op == OP_VISIT);
                dist_we   = q_pop && (cmd.op == OP_DIST_WR);
                dem_we    = q_pop && (cmd.op == OP_DEM_WR);
                rd_en     = visit_pop;
                // legs that touch the depot: (0, p) on port A, (p, 0) on port B
                a_addr    = dist_we ? cmd.addr : AW'(cmd.pt);
                b_addr    = cmd.addr;
            end
            PH_PREV: begin
                // legs from the previous point: (prev, p) and (prev, 0)
                rd_en  = 1'b1;
                a_addr = prev_base_reg + AW'(v_pt_reg);
                b_addr = prev_base_reg;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign credit_next = credit_reg - CRED_W'(visit_pop) + CRED_W'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PH_SLOT;
            credit_reg  <= CRED_W'(OUT_DEPTH);
            c_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            credit_reg  <= credit_next;
            c_valid_reg <= (state_reg == PH_PREV);
        end
    end

    // ---------------- tables ----------------
    always_ff @(posedge aclk) begin
        if (dist_we) begin
            dist_mem[a_addr] <= DIST_WIDTH'(cmd.value);
        end
        if (rd_en) begin
            rd_a_reg <= dist_mem[a_addr];
            rd_b_reg <= dist_mem[b_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dem_we) begin
            dem_mem[cmd.pt] <= DEMAND_WIDTH'(cmd.value);
        end
        if (visit_pop) begin
            need_reg <= dem_mem[cmd.pt];
        end
    end

    // hold visit details; depot legs move aside before the prev legs land
    always_ff @(posedge aclk) begin
        if (visit_pop) begin
            v_pt_reg   <= cmd.pt;
            v_base_reg <= cmd.addr;
            v_last_reg <= cmd.last;
        end
        if (state_reg == PH_PREV) begin
            d0p_reg <= rd_a_reg;
            dp0_reg <= rd_b_reg;
        end
    end

    // ---------------- split decision ----------------
    always_comb begin
        need_x   = CMP_W'(need_reg);
        cap_x    = CMP_W'(vehicle_capacity);
        load_x   = CMP_W'(load_reg);
        sum_x    = load_x + need_x;
        over     = need_x > cap_x;
        ret      = sum_x > cap_x;
        fresh    = ret || (load_reg == '0);
        load_new = fresh ? CAP_W'(need_x) : CAP_W'(sum_x);
        leg      = fresh ? d0p_reg : rd_a_reg;
        delta    = '0;
        if (over) begin
            if (v_last_reg && (load_reg != '0)) begin
                delta = DELTA_W'(rd_b_reg);
            end
        end else begin
            delta = DELTA_W'(leg);
            if (ret) begin
                delta = delta + DELTA_W'(rd_b_reg);
            end
            if (v_last_reg && (load_new != '0)) begin
                delta = delta + DELTA_W'(dp0_reg);
            end
        end

        load_next      = load_reg;
        prev_base_next = prev_base_reg;
        if (c_valid_reg) begin
            if (v_last_reg) begin
                load_next      = '0;
                prev_base_next = '0;
            end else if (!over) begin
                load_next      = load_new;
                prev_base_next = v_base_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg      <= '0;
            prev_base_reg <= '0;
            s3_valid_reg  <= 1'b0;
        end else begin
            load_reg      <= load_next;
            prev_base_reg <= prev_base_next;
            s3_valid_reg  <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_valid_reg) begin
            delta_reg    <= delta;
            s3_fresh_reg <= fresh && !over;
            s3_over_reg  <= over;
            s3_last_reg  <= v_last_reg;
        end
    end

    // ---------------- saturating cost ----------------
    always_comb begin
        sum_w    = SUM_W'(cost_reg) + SUM_W'(delta_reg);
        cost_sat = (sum_w > SUM_W'({COST_W{1'b1}})) ? {COST_W{1'b1}} : COST_W'(sum_w);
        cost_next = cost_reg;
        if (s3_valid_reg) begin
            cost_next = s3_last_reg ? '0 : cost_sat;
        end
        res.running_cost  = cost_sat;
        res.new_subroute  = s3_fresh_reg;
        res.over_capacity = s3_over_reg;
        res.tour_done     = s3_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg <= '0;
        end else begin
            cost_reg <= cost_next;
        end
    end

    cvrp_queue #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s3_valid_reg),
        .push_data  (res),
        .push_ready (o_ready),
        .pop        (m_ready),
        .pop_data   (m_data),
        .pop_valid  (m_valid)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= CRED_W'(OUT_DEPTH))
        else $error("result credit count above queue depth");

    a_res_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> o_ready)
        else $error("result pushed into a full result queue");

    a_visit_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        visit_pop |=> (state_reg == PH_PREV))
        else $error("visit not followed by previous-point read phase");

    a_res_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> $past(visit_pop, 3))
        else $error("cost stage active without a visit three cycles back");
`endif

endmodule

`default_nettype wire
